// File: hdl/vcns_pkg.sv
// Package for the nearest-site core: codes, fixed field widths, geometry constants
// and the geometry result struct. No dependencies.
package vcns_pkg;

  // fixed field widths
  localparam int AREA_W  = 12;  // area width / height and site coordinate ports
  localparam int IDXF_W  = 6;   // site_index and nearest_site fields
  localparam int CELL_W  = 9;   // cell_col / cell_row
  localparam int SIZE_W  = 7;   // cell size, at most 69
  localparam int PCNT_W  = 7;   // point_count register
  localparam int CFGA_W  = 2;   // configuration register index

  // cell size: max(MIN_CELL, ceil(w/W_DIVS), ceil(h/H_DIVS))
  localparam int MIN_CELL = 8;
  localparam int W_DIVS   = 100;
  localparam int H_DIVS   = 60;
  // floor(x/100) = (x*5243)>>19 and floor(x/60) = (x*4370)>>18, exact for x < 4681
  localparam int W_RECIP  = 5243;
  localparam int W_SHIFT  = 19;
  localparam int H_RECIP  = 4370;
  localparam int H_SHIFT  = 18;

  // geometry pipeline depth and the counter that waits it out
  localparam int GEOM_LAT   = 4;
  localparam int GEOM_CNT_W = 2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  typedef enum logic {
    STATUS_OK  = 1'b0,
    STATUS_ERR = 1'b1
  } status_t;

  typedef enum logic [CFGA_W-1:0] {
    CFG_AREA_WIDTH  = 2'd0,
    CFG_AREA_HEIGHT = 2'd1,
    CFG_POINT_COUNT = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEOM,
    ST_CHECK,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              err;
    logic [AREA_W-1:0] px;
    logic [AREA_W-1:0] py;
  } geom_res_t;

endpackage

// File: hdl/voronoi_cell_nearest_site_core.sv
// Nearest-site core top level: config registers, control sequencer, output register.
// Instantiates vcns_geom and vcns_dist; depends on vcns_pkg.
// Load word: written into the site table at the accept edge, ready again next cycle.
// Query word: geometry wait, check, scan of n sites, 3 compare stages, result register;
// n = point_count held to 1..MAX_SITES. An error word goes from the check to the result.
// One word in flight; rst_n (sync, active low) resets control and config, not the site table.
module voronoi_cell_nearest_site_core #(
  parameter int MAX_SITES  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // site_index[5:0], site_x[17:6], site_y[29:18], cell_col[38:30], cell_row[47:39]
  input  logic [47:0]                         in_tdata,
  // opcode[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // nearest_site[5:0], zero pad[7:6]
  output logic [7:0]                          out_tdata,
  // status[0]
  output logic                                out_tuser,
  input  logic                                cfg_we,
  input  logic [vcns_pkg::CFGA_W-1:0]         cfg_addr,
  input  logic [vcns_pkg::AREA_W-1:0]         cfg_wdata
);
  import vcns_pkg::*;

  localparam int IDX_W = $clog2(MAX_SITES);

  state_t state_r, state_nxt;

  logic [AREA_W-1:0]     area_width_r, area_height_r;
  logic [PCNT_W-1:0]     point_count_r;
  logic [CELL_W-1:0]     col_r, row_r;
  logic [GEOM_CNT_W-1:0] gcnt_r;
  logic [IDXF_W-1:0]     res_site_r, out_site_r;
  logic                  res_status_r, out_status_r, out_valid_r;

  logic [IDXF_W-1:0]     f_index;
  logic [AREA_W-1:0]     f_x, f_y;
  logic [CELL_W-1:0]     f_col, f_row;
  logic                  accept, is_query, load_ok, out_free;
  logic                  mem_we, query_take, dist_start, res_err_load, res_scan_load, out_load;

  logic [IDX_W+IDXF_W-1:0]         waddr_ext;
  logic [COORD_BITS+AREA_W-1:0]    wx_ext, wy_ext;
  logic [IDX_W-1:0]                last_idx, best_idx;
  logic [IDX_W+IDXF_W-1:0]         best_ext;
  logic                            dist_done;
  geom_res_t                       geom;

  assign f_index  = in_tdata[5:0];
  assign f_x      = in_tdata[17:6];
  assign f_y      = in_tdata[29:18];
  assign f_col    = in_tdata[38:30];
  assign f_row    = in_tdata[47:39];
  assign accept   = in_tvalid && in_tready;
  assign is_query = (in_tuser == OP_QUERY);
  assign load_ok  = (32'(f_index) < 32'(MAX_SITES));
  assign out_free = !out_valid_r || out_tready;

  // fit the fixed port widths to the table geometry
  assign waddr_ext = {IDX_W'(0), f_index};
  assign wx_ext    = {COORD_BITS'(0), f_x};
  assign wy_ext    = {COORD_BITS'(0), f_y};
  assign best_ext  = {IDXF_W'(0), best_idx};

  // point_count 0 acts as 1, above the table as the table size
  always_comb begin
    if (point_count_r == '0)                         last_idx = '0;
    else if (32'(point_count_r) > 32'(MAX_SITES))    last_idx = IDX_W'(MAX_SITES - 1);
    else                                             last_idx = IDX_W'(point_count_r - PCNT_W'(1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && is_query) state_nxt = ST_GEOM;
      ST_GEOM:  if (gcnt_r == GEOM_CNT_W'(GEOM_LAT - 1)) state_nxt = ST_CHECK;
      ST_CHECK: state_nxt = geom.err ? ST_DONE : ST_SCAN;
      ST_SCAN:  if (dist_done) state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_tready     = 1'b0;
    mem_we        = 1'b0;
    query_take    = 1'b0;
    dist_start    = 1'b0;
    res_err_load  = 1'b0;
    res_scan_load = 1'b0;
    out_load      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        mem_we     = in_tvalid && !is_query && load_ok;
        query_take = in_tvalid && is_query;
      end
      ST_GEOM:  ;
      ST_CHECK: begin
        dist_start   = !geom.err;
        res_err_load = geom.err;
      end
      ST_SCAN:  res_scan_load = dist_done;
      ST_DONE:  out_load = out_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      area_width_r  <= '0;
      area_height_r <= '0;
      point_count_r <= PCNT_W'(5);
      gcnt_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_AREA_WIDTH:  area_width_r  <= cfg_wdata;
          CFG_AREA_HEIGHT: area_height_r <= cfg_wdata;
          CFG_POINT_COUNT: point_count_r <= cfg_wdata[PCNT_W-1:0];
          default: ;
        endcase
      end
      if (query_take)            gcnt_r <= '0;
      else if (state_r == ST_GEOM) gcnt_r <= gcnt_r + GEOM_CNT_W'(1);
      if (out_load)        out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (query_take) begin
      col_r <= f_col;
      row_r <= f_row;
    end
    if (res_err_load) begin
      res_site_r   <= '0;
      res_status_r <= STATUS_ERR;
    end else if (res_scan_load) begin
      res_site_r   <= best_ext[IDXF_W-1:0];
      res_status_r <= STATUS_OK;
    end
    if (out_load) begin
      out_site_r   <= res_site_r;
      out_status_r <= res_status_r;
    end
  end

  vcns_geom u_geom (
    .clk         (clk),
    .area_width  (area_width_r),
    .area_height (area_height_r),
    .cell_col    (col_r),
    .cell_row    (row_r),
    .geom        (geom)
  );

  vcns_dist #(
    .MAX_SITES  (MAX_SITES),
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (mem_we),
    .wr_addr  (waddr_ext[IDX_W-1:0]),
    .wr_x     (wx_ext[COORD_BITS-1:0]),
    .wr_y     (wy_ext[COORD_BITS-1:0]),
    .start    (dist_start),
    .last_idx (last_idx),
    .px       (geom.px),
    .py       (geom.py),
    .done     (dist_done),
    .best_idx (best_idx)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_site_r};
  assign out_tuser  = out_status_r;

`ifndef ASSERT_OFF
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    dist_done |-> state_r == ST_SCAN)
    else $error("distance unit finished outside scan");

  a_query_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == OP_QUERY |=> !in_tready)
    else $error("input taken again while a query is running");

  a_err_site_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STATUS_ERR |-> out_tdata[5:0] == '0)
    else $error("error word carries a nonzero site");

  a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && out_free |=> out_tvalid && state_r == ST_IDLE)
    else $error("finished result not moved to the output register");
`endif

endmodule

// File: hdl/vcns_geom.sv
// Cell geometry pipeline: cell size, grid bounds check and clamped cell center.
// Four register stages, free running. Depends on vcns_pkg.
module vcns_geom (
  input  logic                       clk,
  input  logic [vcns_pkg::AREA_W-1:0] area_width,
  input  logic [vcns_pkg::AREA_W-1:0] area_height,
  input  logic [vcns_pkg::CELL_W-1:0] cell_col,
  input  logic [vcns_pkg::CELL_W-1:0] cell_row,
  output vcns_pkg::geom_res_t         geom
);
  import vcns_pkg::*;

  localparam int ADD_W  = AREA_W + 1;
  localparam int RPROD_W = 2 * ADD_W;
  localparam int PROD_W = CELL_W + SIZE_W;

  logic [ADD_W-1:0]    w_up, h_up;
  logic [RPROD_W-1:0]  w_prod, h_prod;
  logic [RPROD_W-1:0]  qw_full, qh_full;
  logic [SIZE_W:0]     qw_r, qh_r;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [PROD_W-1:0]   colp_r, rowp_r;
  logic [SIZE_W-1:0]   half_r;
  logic [PROD_W:0]     px_full, py_full;
  logic [AREA_W-1:0]   wm1, hm1;
  logic                err_nxt;
  geom_res_t           geom_r;

  // stage 1: ceil(w/100) and ceil(h/60) by reciprocal multiply
  assign w_up    = ADD_W'(area_width) + ADD_W'(W_DIVS - 1);
  assign h_up    = ADD_W'(area_height) + ADD_W'(H_DIVS - 1);
  assign w_prod  = RPROD_W'(w_up) * RPROD_W'(W_RECIP);
  assign h_prod  = RPROD_W'(h_up) * RPROD_W'(H_RECIP);
  assign qw_full = w_prod >> W_SHIFT;
  assign qh_full = h_prod >> H_SHIFT;

  // stage 2: size = max of the three
  always_comb begin
    size_nxt = SIZE_W'(MIN_CELL);
    if (qw_r > (SIZE_W+1)'(size_nxt)) size_nxt = qw_r[SIZE_W-1:0];
    if (qh_r > (SIZE_W+1)'(size_nxt)) size_nxt = qh_r[SIZE_W-1:0];
  end

  // stage 4: col < ceil(w/size) is the same as col*size < w
  assign wm1     = area_width - AREA_W'(1);
  assign hm1     = area_height - AREA_W'(1);
  assign px_full = (PROD_W+1)'(colp_r) + (PROD_W+1)'(half_r);
  assign py_full = (PROD_W+1)'(rowp_r) + (PROD_W+1)'(half_r);
  assign err_nxt = (area_width == '0) || (area_height == '0) ||
                   (colp_r >= PROD_W'(area_width)) || (rowp_r >= PROD_W'(area_height));

  always_ff @(posedge clk) begin
    qw_r   <= qw_full[SIZE_W:0];
    qh_r   <= qh_full[SIZE_W:0];
    size_r <= size_nxt;
    colp_r <= PROD_W'(cell_col) * PROD_W'(size_r);
    rowp_r <= PROD_W'(cell_row) * PROD_W'(size_r);
    half_r <= size_r >> 1;
    geom_r.err <= err_nxt;
    geom_r.px  <= (px_full > (PROD_W+1)'(wm1)) ? wm1 : px_full[AREA_W-1:0];
    geom_r.py  <= (py_full > (PROD_W+1)'(hm1)) ? hm1 : py_full[AREA_W-1:0];
  end

  assign geom = geom_r;

endmodule

// File: hdl/vcns_dist.sv
// Site table and the shared distance-compare unit: one site per cycle through
// read, square and compare stages, keeping the first least distance. Depends on vcns_pkg.
module vcns_dist #(
  parameter int MAX_SITES  = 64,
  parameter int COORD_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [$clog2(MAX_SITES)-1:0]       wr_addr,
  input  logic [COORD_BITS-1:0]              wr_x,
  input  logic [COORD_BITS-1:0]              wr_y,
  input  logic                               start,
  input  logic [$clog2(MAX_SITES)-1:0]       last_idx,
  input  logic [vcns_pkg::AREA_W-1:0]        px,
  input  logic [vcns_pkg::AREA_W-1:0]        py,
  output logic                               done,
  output logic [$clog2(MAX_SITES)-1:0]       best_idx
);
  import vcns_pkg::*;

  localparam int IDX_W = $clog2(MAX_SITES);
  localparam int CW    = (COORD_BITS > AREA_W) ? COORD_BITS : AREA_W;
  localparam int SQ_W  = 2 * CW;
  localparam int SUM_W = SQ_W + 1;

  logic [2*COORD_BITS-1:0] site_mem [MAX_SITES];

  logic                    iss_r, v1_r, v2_r, l1_r, l2_r, done_r;
  logic [IDX_W-1:0]        rd_idx_r, i1_r, i2_r, best_idx_r;
  logic [2*COORD_BITS-1:0] rdat_r;
  logic [CW-1:0]           px_e, py_e, sx, sy, dx, dy;
  logic [SQ_W-1:0]         sqx_r, sqy_r;
  logic [SUM_W-1:0]        sum, best_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      site_mem[wr_addr] <= {wr_y, wr_x};
    end
    if (iss_r) begin
      rdat_r <= site_mem[rd_idx_r];
    end
  end

  assign px_e = CW'(px);
  assign py_e = CW'(py);
  assign sx   = CW'(rdat_r[COORD_BITS-1:0]);
  assign sy   = CW'(rdat_r[2*COORD_BITS-1:COORD_BITS]);
  assign dx   = (px_e > sx) ? (px_e - sx) : (sx - px_e);
  assign dy   = (py_e > sy) ? (py_e - sy) : (sy - py_e);
  assign sum  = SUM_W'(sqx_r) + SUM_W'(sqy_r);

  // sequencer and stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iss_r    <= 1'b0;
      rd_idx_r <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (start) begin
        iss_r    <= 1'b1;
        rd_idx_r <= '0;
      end else if (iss_r) begin
        if (rd_idx_r == last_idx) iss_r <= 1'b0;
        else                      rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
      v1_r   <= iss_r;
      v2_r   <= v1_r;
      done_r <= v2_r && l2_r;
    end
  end

  // datapath stages
  always_ff @(posedge clk) begin
    i1_r  <= rd_idx_r;
    l1_r  <= (rd_idx_r == last_idx);
    i2_r  <= i1_r;
    l2_r  <= l1_r;
    sqx_r <= SQ_W'(dx) * SQ_W'(dx);
    sqy_r <= SQ_W'(dy) * SQ_W'(dy);
    // strict less keeps the lowest index on a tie
    if (v2_r && ((i2_r == '0) || (sum < best_r))) begin
      best_r     <= sum;
      best_idx_r <= i2_r;
    end
  end

  assign done     = done_r;
  assign best_idx = best_idx_r;

`ifndef ASSERT_OFF
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(v2_r) && $past(l2_r))
    else $error("done without last site in compare stage");

  a_issue_stops: assert property (@(posedge clk) disable iff (!rst_n)
    iss_r && !start && (rd_idx_r == last_idx) |=> !iss_r || $past(start))
    else $error("site scan ran past last index");

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !iss_r && !v1_r && !v2_r)
    else $error("scan started while unit busy");
`endif

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for voronoi_cell_nearest_site_core: site loads, cell queries,
// area and site count settings, random stalls on both streams. Depends on vcns_pkg.
module tb;
  import vcns_pkg::*;

  localparam int          DRAIN_CYCLES = 90;       // longest scan plus geometry and tail
  localparam int          LONG_HOLD    = 300;
  localparam int          PHASE_WORDS  = 170;
  localparam int          NUM_PHASES   = 10;
  localparam int          DIR_ROWS     = 29;
  localparam int unsigned CYCLE_LIMIT  = 2000000;
  localparam int unsigned NUM_SITES    = 64;

  // register index that decodes to nothing
  localparam logic [CFGA_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [IDXF_W-1:0] site;
    status_t           status;
  } answer_t;

  typedef struct {
    int unsigned span;
    int unsigned cols;
    int unsigned rows;
  } grid_t;

  typedef enum logic [1:0] {
    ROW_LOAD,
    ROW_QUERY,
    ROW_REG
  } row_kind_t;

  // p0..p2 - load: slot, x, y; query: col, row; register: index, value
  typedef struct {
    row_kind_t   kind;
    int unsigned p0;
    int unsigned p1;
    int unsigned p2;
    bit          typed;
    answer_t     ans;
  } row_t;

  typedef struct {
    int unsigned w;
    int unsigned h;
    int unsigned n;
  } setting_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [47:0]         in_tdata;
  logic                in_tuser;
  logic                out_tvalid;
  logic                out_tready;
  logic [7:0]          out_tdata;
  logic                out_tuser;
  logic                cfg_we;
  logic [CFGA_W-1:0]   cfg_addr;
  logic [AREA_W-1:0]   cfg_wdata;

  // predictor state
  int unsigned grid_width;
  int unsigned grid_height;
  int unsigned sites_in_play;
  int unsigned site_xs [NUM_SITES];
  int unsigned site_ys [NUM_SITES];
  answer_t     pending_answers [$];

  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_req;
  int          mismatches;
  int          loads_sent;
  int          queries_sent;
  int          error_answers;
  int          reg_writes;
  int unsigned cycles;

  row_t dir_rows [DIR_ROWS] = '{
    '{ROW_QUERY, 0,    0,    0,    1'b1, '{6'd0, STATUS_ERR}},  // empty area after reset
    '{ROW_LOAD,  0,    0,    0,    1'b0, '{6'd0, STATUS_OK}},
    '{ROW_LOAD,  1,    4095, 4095, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_LOAD,  2,    4095, 0,    1'b0, '{6'd0, STATUS_OK}},
    '{ROW_LOAD,  3,    0,    4095, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_LOAD,  4,    0,    0,    1'b0, '{6'd0, STATUS_OK}},   // ties with slot 0
    '{ROW_REG,   CFG_AREA_WIDTH,  800,  0, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_QUERY, 0,    0,    0,    1'b1, '{6'd0, STATUS_ERR}},  // height still zero
    '{ROW_REG,   CFG_AREA_HEIGHT, 480,  0, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_QUERY, 0,    0,    0,    1'b0, '{6'd0, STATUS_OK}},
    '{ROW_QUERY, 99,   59,   0,    1'b0, '{6'd0, STATUS_OK}},
    '{ROW_QUERY, 100,  0,    0,    1'b1, '{6'd0, STATUS_ERR}},
    '{ROW_QUERY, 0,    60,   0,    1'b1, '{6'd0, STATUS_ERR}},
    '{ROW_QUERY, 511,  511,  0,    1'b1, '{6'd0, STATUS_ERR}},
    '{ROW_REG,   CFG_POINT_COUNT, 0,    0, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_QUERY, 99,   59,   0,    1'b1, '{6'd0, STATUS_OK}},   // count 0 scans slot 0 only
    '{ROW_REG,   CFG_AREA_WIDTH,  4095, 0, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_REG,   CFG_AREA_HEIGHT, 4095, 0, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_REG,   CFG_POINT_COUNT, 5,    0, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_QUERY, 59,   59,   0,    1'b0, '{6'd0, STATUS_OK}},   // centre clamps to the corner
    '{ROW_QUERY, 0,    59,   0,    1'b0, '{6'd0, STATUS_OK}},
    '{ROW_LOAD,  63,   4095, 2048, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_REG,   CFG_SPARE,       4095, 0, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_QUERY, 30,   30,   0,    1'b0, '{6'd0, STATUS_OK}},
    '{ROW_REG,   CFG_AREA_WIDTH,  1,    0, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_REG,   CFG_AREA_HEIGHT, 1,    0, 1'b0, '{6'd0, STATUS_OK}},
    '{ROW_QUERY, 0,    0,    0,    1'b0, '{6'd0, STATUS_OK}},   // most sites lie outside the area
    '{ROW_QUERY, 1,    0,    0,    1'b1, '{6'd0, STATUS_ERR}},
    '{ROW_QUERY, 0,    1,    0,    1'b1, '{6'd0, STATUS_ERR}}
  };

  setting_t settings [NUM_PHASES] = '{
    '{800,  480,  64},
    '{4095, 4095, 64},
    '{1,    1,    1},
    '{4095, 1,    127},
    '{1,    4095, 0},
    '{640,  400,  16},
    '{0,    300,  8},
    '{300,  0,    3},
    '{100,  60,   33},
    '{2047, 1234, 64}
  };

  voronoi_cell_nearest_site_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic grid_t grid_of();
    grid_t g;
    g.span = MIN_CELL;
    if ((grid_width + W_DIVS - 1) / W_DIVS > g.span) g.span = (grid_width + W_DIVS - 1) / W_DIVS;
    if ((grid_height + H_DIVS - 1) / H_DIVS > g.span)
      g.span = (grid_height + H_DIVS - 1) / H_DIVS;
    if (grid_width == 0 || grid_height == 0) begin
      g.cols = 0;
      g.rows = 0;
    end else begin
      g.cols = (grid_width + g.span - 1) / g.span;
      g.rows = (grid_height + g.span - 1) / g.span;
    end
    return g;
  endfunction

  function automatic int unsigned sites_scanned();
    if (sites_in_play == 0) return 1;
    if (sites_in_play > NUM_SITES) return NUM_SITES;
    return sites_in_play;
  endfunction

  function automatic answer_t nearest_site_of(int unsigned col, int unsigned rowi);
    grid_t       g;
    int unsigned cx, cy, best_i;
    int          dx, dy;
    longint      best, d;
    answer_t     a;
    g = grid_of();
    a.site = '0;
    a.status = STATUS_ERR;
    // empty area leaves cols and rows at zero, so it lands here too
    if (col >= g.cols || rowi >= g.rows) return a;
    cx = col * g.span + g.span / 2;
    if (cx > grid_width - 1) cx = grid_width - 1;
    cy = rowi * g.span + g.span / 2;
    if (cy > grid_height - 1) cy = grid_height - 1;
    best_i = 0;
    best = longint'(1) << 40;
    for (int i = 0; i < sites_scanned(); i++) begin
      dx = int'(cx) - int'(site_xs[i]);
      dy = int'(cy) - int'(site_ys[i]);
      d = longint'(dx) * dx + longint'(dy) * dy;
      if (d < best) begin   // strict: lowest index keeps a tie
        best = d;
        best_i = i;
      end
    end
    a.site = best_i[IDXF_W-1:0];
    a.status = STATUS_OK;
    return a;
  endfunction

  task automatic note_mismatch(string what, int got, int want);
    mismatches++;
    $display("MISMATCH at cycle %0d: %s got %0d, want %0d", cycles, what, got, want);
  endtask

  task automatic go_quiet();
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic wait_all_answered();
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic send_word(opcode_t op, int unsigned slot, int unsigned x, int unsigned y,
                           int unsigned col, int unsigned rowi, bit typed, answer_t typed_ans);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {rowi[CELL_W-1:0], col[CELL_W-1:0], y[AREA_W-1:0], x[AREA_W-1:0],
                  slot[IDXF_W-1:0]};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (op == OP_LOAD) begin
      site_xs[slot[IDXF_W-1:0]] = x[AREA_W-1:0];
      site_ys[slot[IDXF_W-1:0]] = y[AREA_W-1:0];
      loads_sent++;
    end else begin
      pending_answers.push_back(typed ? typed_ans : nearest_site_of(col, rowi));
      if (pending_answers[$].status == STATUS_ERR) error_answers++;
      queries_sent++;
    end
  endtask

  task automatic write_reg(logic [CFGA_W-1:0] idx, int unsigned value);
    go_quiet();
    wait_all_answered();
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[AREA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_AREA_WIDTH:  grid_width = value & 32'hFFF;
      CFG_AREA_HEIGHT: grid_height = value & 32'hFFF;
      CFG_POINT_COUNT: sites_in_play = value & 32'h7F;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic random_load();
    int unsigned slot, x, y, twin, r;
    slot = $urandom_range(1) ? $urandom_range(NUM_SITES - 1) : $urandom_range(sites_scanned() - 1);
    r = $urandom_range(99);
    if (r < 15) begin
      // copy another site to make exact distance ties
      twin = $urandom_range(NUM_SITES - 1);
      x = site_xs[twin];
      y = site_ys[twin];
    end else if (r < 35 || grid_width == 0 || grid_height == 0) begin
      x = $urandom_range(4095);
      y = $urandom_range(4095);
    end else begin
      x = $urandom_range(grid_width - 1);
      y = $urandom_range(grid_height - 1);
    end
    send_word(OP_LOAD, slot, x, y, $urandom_range(511), $urandom_range(511), 1'b0, '0);
  endtask

  task automatic random_query();
    grid_t       g;
    int unsigned col, rowi, r;
    g = grid_of();
    r = $urandom_range(99);
    if (g.cols == 0 || r < 12) begin
      col  = $urandom_range(511);
      rowi = $urandom_range(511);
    end else if (r < 20) begin
      col  = g.cols - 1;
      rowi = g.rows - 1;
    end else begin
      col  = $urandom_range(g.cols - 1);
      rowi = $urandom_range(g.rows - 1);
    end
    send_word(OP_QUERY, $urandom_range(63), $urandom_range(4095), $urandom_range(4095),
              col, rowi, 1'b0, '0);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    answer_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (pending_answers.size() == 0) begin
          note_mismatch("unexpected result word, nearest_site", out_tdata[IDXF_W-1:0], -1);
        end else begin
          want = pending_answers.pop_front();
          if (out_tdata[IDXF_W-1:0] !== want.site)
            note_mismatch("nearest_site", out_tdata[IDXF_W-1:0], want.site);
          if (out_tuser !== want.status)
            note_mismatch("status", out_tuser, want.status);
        end
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", cycles,
             pending_answers.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_LOAD;
    cfg_we    = 1'b0;
    cfg_addr  = CFG_AREA_WIDTH;
    cfg_wdata = '0;
    hold_req  = 1'b0;
    mismatches = 0;
    loads_sent = 0;
    queries_sent = 0;
    error_answers = 0;
    reg_writes = 0;
    grid_width = 0;
    grid_height = 0;
    sites_in_play = 5;
    foreach (site_xs[i]) begin
      site_xs[i] = 0;
      site_ys[i] = 0;
    end
    tx_idle_pct = 24;
    rx_idle_pct = 49;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      case (dir_rows[i].kind)
        ROW_REG:  write_reg(dir_rows[i].p0[CFGA_W-1:0], dir_rows[i].p1);
        ROW_LOAD: send_word(OP_LOAD, dir_rows[i].p0, dir_rows[i].p1, dir_rows[i].p2, 0, 0,
                            1'b0, '0);
        default:  send_word(OP_QUERY, 0, 0, 0, dir_rows[i].p0, dir_rows[i].p1,
                            dir_rows[i].typed, dir_rows[i].ans);
      endcase
    end

    // fill the whole table so any site count only reads loaded slots
    for (int s = 0; s < NUM_SITES; s++)
      send_word(OP_LOAD, s, $urandom_range(4095), $urandom_range(4095), $urandom_range(511),
                $urandom_range(511), 1'b0, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 4) begin
        tx_idle_pct = 24;
        rx_idle_pct = 49;
      end else if (p < 7) begin
        tx_idle_pct = 49;
        rx_idle_pct = 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_reg(CFG_AREA_WIDTH, settings[p].w);
      write_reg(CFG_AREA_HEIGHT, settings[p].h);
      write_reg(CFG_POINT_COUNT, settings[p].n);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (p == 1 && k == 40) hold_req = 1'b1;
        if (p == 4 && k == 80) begin
          go_quiet();
          wait_all_answered();
        end
        if ($urandom_range(99) < 25) random_load();
        else random_query();
      end
    end

    go_quiet();
    wait_all_answered();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d site loads and %0d cell queries (%0d with error status), %0d reg writes",
             loads_sent, queries_sent, error_answers, reg_writes);
    $display("Stall mixes 24/49, 49/24 and none, one long result hold, %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
